@@ hw/rtl/ascii_left_to_right_calculator_macros.svh @@
// Assertion helpers used by the calculator RTL.
`ifndef ASCII_LEFT_TO_RIGHT_CALCULATOR_MACROS_SVH
`define ASCII_LEFT_TO_RIGHT_CALCULATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ALRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ALRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/alrc_pkg.sv @@
package alrc_pkg;

  localparam int VALUE_BITS_DEF = 64;

  // Operations of the shared arithmetic unit.
  typedef enum logic [2:0] {
    UOP_ADD,
    UOP_SUB,
    UOP_MUL,
    UOP_DIV,
    UOP_DIG
  } uop_t;

  typedef struct packed {
    logic start;
    uop_t op;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

@@ hw/rtl/alrc_iter_unit.sv @@
module alrc_iter_unit #(
  parameter int W = alrc_pkg::VALUE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  alrc_pkg::unit_req_t    req,
  input  logic [W-1:0]           opa,
  input  logic [W-1:0]           opb,
  output alrc_pkg::unit_stat_t   stat,
  output logic [W-1:0]           result
);

  localparam int AW = W + 2;
  localparam int CW = $clog2(W);

  typedef enum logic [3:0] {
    U_IDLE,
    U_ARITH,
    U_MUL,
    U_DNA,
    U_DNB,
    U_DIV,
    U_DFIX,
    U_DIG1,
    U_DIG2,
    U_DONE
  } ustate_t;

  ustate_t        state_r;
  logic [W-1:0]   x_r;
  logic [W-1:0]   y_r;
  logic [W-1:0]   z_r;
  logic [CW-1:0]  cnt_r;
  logic           sub_r;
  logic           sa_r;
  logic           sb_r;

  logic [AW-1:0]  add_a;
  logic [AW-1:0]  add_b;
  logic [AW-1:0]  add_sum;
  logic           add_sub;
  logic           last_step;

  // The one adder/subtractor that every operation goes through.
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (state_r)
      U_ARITH: begin
        add_a   = AW'(x_r);
        add_b   = AW'(y_r);
        add_sub = sub_r;
      end
      U_MUL: begin
        add_a = AW'(z_r);
        add_b = y_r[0] ? AW'(x_r) : '0;
      end
      U_DNA: begin
        add_b   = AW'(y_r);
        add_sub = 1'b1;
      end
      U_DNB: begin
        add_b   = AW'(x_r);
        add_sub = 1'b1;
      end
      U_DIV: begin
        // Trial subtraction of the divisor from the shifted partial remainder.
        add_a   = AW'({z_r, y_r[W-1]});
        add_b   = AW'(x_r);
        add_sub = 1'b1;
      end
      U_DFIX: begin
        add_b   = AW'(y_r);
        add_sub = 1'b1;
      end
      U_DIG1: begin
        add_a = AW'({x_r[W-4:0], 3'b000});
        add_b = AW'({x_r[W-2:0], 1'b0});
      end
      U_DIG2: begin
        add_a = AW'(z_r);
        add_b = AW'(y_r);
      end
      default: begin
        add_a = '0;
      end
    endcase
    add_sum = add_a + (add_b ^ {AW{add_sub}}) + AW'(add_sub);
  end

  assign last_step = (cnt_r == CW'(W - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
    end else begin
      case (state_r)
        U_IDLE: begin
          if (req.start) begin
            // For a divide the dividend shifts through y and the divisor sits in x.
            x_r   <= (req.op == alrc_pkg::UOP_DIV) ? opb : opa;
            y_r   <= (req.op == alrc_pkg::UOP_DIV) ? opa : opb;
            z_r   <= '0;
            cnt_r <= '0;
            sub_r <= (req.op == alrc_pkg::UOP_SUB);
            sa_r  <= opa[W-1];
            sb_r  <= opb[W-1];
            case (req.op)
              alrc_pkg::UOP_ADD, alrc_pkg::UOP_SUB: state_r <= U_ARITH;
              alrc_pkg::UOP_MUL: state_r <= U_MUL;
              alrc_pkg::UOP_DIV: state_r <= U_DNA;
              alrc_pkg::UOP_DIG: state_r <= U_DIG1;
              default: state_r <= U_IDLE;
            endcase
          end
        end
        U_ARITH: begin
          z_r     <= add_sum[W-1:0];
          state_r <= U_DONE;
        end
        U_MUL: begin
          z_r   <= add_sum[W-1:0];
          x_r   <= x_r << 1;
          y_r   <= y_r >> 1;
          cnt_r <= cnt_r + CW'(1);
          if (last_step) begin
            state_r <= U_DONE;
          end
        end
        U_DNA: begin
          if (sa_r) begin
            y_r <= add_sum[W-1:0];
          end
          state_r <= U_DNB;
        end
        U_DNB: begin
          if (sb_r) begin
            x_r <= add_sum[W-1:0];
          end
          state_r <= U_DIV;
        end
        U_DIV: begin
          if (add_sum[AW-1]) begin
            z_r <= {z_r[W-2:0], y_r[W-1]};
            y_r <= {y_r[W-2:0], 1'b0};
          end else begin
            z_r <= add_sum[W-1:0];
            y_r <= {y_r[W-2:0], 1'b1};
          end
          cnt_r <= cnt_r + CW'(1);
          if (last_step) begin
            state_r <= U_DFIX;
          end
        end
        U_DFIX: begin
          z_r     <= (sa_r ^ sb_r) ? add_sum[W-1:0] : y_r;
          state_r <= U_DONE;
        end
        U_DIG1: begin
          z_r     <= add_sum[W-1:0];
          state_r <= U_DIG2;
        end
        U_DIG2: begin
          z_r     <= add_sum[W-1:0];
          state_r <= U_DONE;
        end
        U_DONE: begin
          state_r <= U_IDLE;
        end
        default: begin
          state_r <= U_IDLE;
        end
      endcase
    end
  end

  assign stat.busy = (state_r != U_IDLE);
  assign stat.done = (state_r == U_DONE);
  assign result    = z_r;

endmodule

@@ hw/rtl/ascii_left_to_right_calculator.sv @@
// Channel   Direction  Payload
// in_       slave      tdata[7:0] = character
// out_      master     tdata[63:0] = value
//
// A digit and each applied operator run through the shared adder unit, a multiply
// and a divide as bit-serial loops; a skipped operator bypasses the unit and a
// terminator ends with an emit step. in_tready is high only while the sequencer
// is idle. rst_n is synchronous and clears the total, the number and the
// operator. A finished result waits in the output register while new input is
// taken; the next terminator stalls until that result has been taken.
`include "ascii_left_to_right_calculator_macros.svh"

module ascii_left_to_right_calculator #(
  parameter int VALUE_BITS = alrc_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] character
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // [63:0] value
);

  localparam logic [7:0] CH_END  = 8'h00;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  typedef enum logic [2:0] {
    P_ADD,
    P_SUB,
    P_MUL,
    P_DIV,
    P_NONE
  } pop_t;

  typedef enum logic [2:0] {
    T_IDLE,
    T_DIGIT,
    T_APPLY,
    T_POST,
    T_EMIT
  } tstate_t;

  tstate_t                state_r;
  logic [VALUE_BITS-1:0]  total_r;
  logic [VALUE_BITS-1:0]  pend_r;
  pop_t                   pop_r;
  pop_t                   next_op_r;
  logic                   term_r;
  logic                   out_tvalid_r;
  logic [63:0]            out_data_r;

  alrc_pkg::unit_req_t    ureq;
  alrc_pkg::unit_stat_t   ust;
  logic [VALUE_BITS-1:0]  u_opa;
  logic [VALUE_BITS-1:0]  u_opb;
  logic [VALUE_BITS-1:0]  u_result;

  logic  accept;
  logic  is_digit;
  logic  skip_apply;
  pop_t  char_op;

  assign in_tready = (state_r == T_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    is_digit   = in_tdata inside {[CH_ZERO:CH_NINE]};
    // The unknown operator and a division by zero leave the total as it is.
    skip_apply = (pop_r == P_NONE) || ((pop_r == P_DIV) && (pend_r == '0));
    case (in_tdata)
      CH_PLUS:  char_op = P_ADD;
      CH_MINUS: char_op = P_SUB;
      CH_STAR:  char_op = P_MUL;
      CH_SLASH: char_op = P_DIV;
      default:  char_op = P_NONE;
    endcase
    ureq.start = accept && (is_digit || !skip_apply);
    if (is_digit) begin
      ureq.op = alrc_pkg::UOP_DIG;
    end else begin
      case (pop_r)
        P_SUB:   ureq.op = alrc_pkg::UOP_SUB;
        P_MUL:   ureq.op = alrc_pkg::UOP_MUL;
        P_DIV:   ureq.op = alrc_pkg::UOP_DIV;
        default: ureq.op = alrc_pkg::UOP_ADD;
      endcase
    end
    // The low nibble of an ASCII digit is its value.
    u_opa = is_digit ? pend_r : total_r;
    u_opb = is_digit ? VALUE_BITS'(in_tdata[3:0]) : pend_r;
  end

  alrc_iter_unit #(
    .W (VALUE_BITS)
  ) u_unit (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (ureq),
    .opa    (u_opa),
    .opb    (u_opb),
    .stat   (ust),
    .result (u_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= T_IDLE;
      out_tvalid_r <= 1'b0;
      total_r      <= '0;
      pend_r       <= '0;
      pop_r        <= P_ADD;
    end else begin
      // In the emit state the output register is handled below.
      if (out_tvalid_r && out_tready && (state_r != T_EMIT)) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        T_IDLE: begin
          if (accept) begin
            if (is_digit) begin
              state_r <= T_DIGIT;
            end else begin
              next_op_r <= char_op;
              term_r    <= (in_tdata == CH_END);
              state_r   <= skip_apply ? T_POST : T_APPLY;
            end
          end
        end
        T_DIGIT: begin
          if (ust.done) begin
            pend_r  <= u_result;
            state_r <= T_IDLE;
          end
        end
        T_APPLY: begin
          if (ust.done) begin
            total_r <= u_result;
            state_r <= T_POST;
          end
        end
        T_POST: begin
          pend_r <= '0;
          if (term_r) begin
            state_r <= T_EMIT;
          end else begin
            pop_r   <= next_op_r;
            state_r <= T_IDLE;
          end
        end
        T_EMIT: begin
          if (!out_tvalid_r || out_tready) begin
            out_data_r   <= 64'($signed(total_r));
            out_tvalid_r <= 1'b1;
            total_r      <= '0;
            pend_r       <= '0;
            pop_r        <= P_ADD;
            state_r      <= T_IDLE;
          end
        end
        default: begin
          state_r <= T_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  `ALRC_ASSERT_IMP(a_ready_unit_idle, clk, rst_n, in_tready, !ust.busy, "input ready while unit busy")
  `ALRC_ASSERT_IMP(a_done_expected, clk, rst_n, ust.done, (state_r == T_DIGIT) || (state_r == T_APPLY), "unit finished with no waiting step")
  `ALRC_ASSERT_NXT(a_end_blocks, clk, rst_n, accept && (in_tdata == CH_END), !in_tready, "terminator did not stall input")

endmodule
